// ===== rtl/core/dkpq_pkg.sv =====
// ----------------------------------------------------------------------------
// dkpq_pkg
// shared types and constants of the date keyed priority queue
// ----------------------------------------------------------------------------
package dkpq_pkg;

    localparam int unsigned COURSE_W = 3;
    localparam int unsigned NUMBER_W = 16;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned DAYS_W   = 10;

    localparam logic [MONTH_W-1:0]  MONTH_MAX = MONTH_W'(12);
    localparam logic [DAY_W-1:0]    DAY_MAX   = DAY_W'(31);
    localparam logic [COURSE_W-1:0] NO_COURSE = COURSE_W'(6);
    localparam int unsigned         DAYS_PER_MONTH = 30;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_QUERY  = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic {
        CFG_MONTH = 1'b0,
        CFG_DAY   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [COURSE_W-1:0] course;
        logic [NUMBER_W-1:0] number;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } entry_t;

    typedef struct packed {
        logic                     earlier;
        logic                     match;
        logic signed [DAYS_W-1:0] days;
    } alu_res_t;

endpackage

// ===== rtl/core/dkpq_store.sv =====
// ----------------------------------------------------------------------------
// dkpq_store
// entry memory, one write port and one read port with registered data
// ----------------------------------------------------------------------------
module dkpq_store #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned ADDR_W = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  dkpq_pkg::entry_t    wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output dkpq_pkg::entry_t    rd_data
);
    import dkpq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/dkpq_alu.sv =====
// ----------------------------------------------------------------------------
// dkpq_alu
// shared compare unit: date order, course match and days until due
// ----------------------------------------------------------------------------
module dkpq_alu (
    input  dkpq_pkg::entry_t                  entry,
    input  logic [dkpq_pkg::MONTH_W-1:0]      new_month,
    input  logic [dkpq_pkg::DAY_W-1:0]        new_day,
    input  logic [dkpq_pkg::COURSE_W-1:0]     key_course,
    input  logic [dkpq_pkg::MONTH_W-1:0]      cur_month,
    input  logic [dkpq_pkg::DAY_W-1:0]        cur_day,
    output dkpq_pkg::alu_res_t                res
);
    import dkpq_pkg::*;

    localparam int unsigned SUM_W = DAYS_W + 1;

    logic signed [SUM_W-1:0] dm;
    logic signed [SUM_W-1:0] dd;
    logic signed [SUM_W-1:0] scaled;
    logic signed [SUM_W-1:0] total;

    always_comb
    begin
        dm     = $signed(SUM_W'(entry.month)) - $signed(SUM_W'(cur_month));
        dd     = $signed(SUM_W'(entry.day)) - $signed(SUM_W'(cur_day));
        // times thirty as 32x - 2x
        scaled = (dm <<< 5) - (dm <<< 1);
        total  = scaled + dd;

        if (new_month != entry.month)
        begin
            res.earlier = (new_month < entry.month);
        end
        else
        begin
            res.earlier = (new_day < entry.day);
        end
        res.match = (entry.course == key_course);
        res.days  = total[DAYS_W-1:0];
    end

endmodule

// ===== rtl/core/date_keyed_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// date_keyed_priority_queue_top
// sorted priority queue of dated entries on a circular entry memory
// ----------------------------------------------------------------------------
// rejected commands, full, empty and insert into an empty queue: done in the cycle after start
// insert: moves the entries after the new one up one place, one memory read and move per cycle
// remove: reads the head entry and returns it; query: reads from the head to the first matching entry
// one command at a time, busy high until the done cycle; done is never stalled
// reset empties the queue and sets the date to month 1, day 1; memory is not cleared
// ----------------------------------------------------------------------------
module date_keyed_priority_queue_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [dkpq_pkg::DAY_W-1:0]          cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic [dkpq_pkg::COURSE_W-1:0]       course_id,
    input  logic [dkpq_pkg::NUMBER_W-1:0]       item_number,
    input  logic [dkpq_pkg::MONTH_W-1:0]        due_month,
    input  logic [dkpq_pkg::DAY_W-1:0]          due_day,
    output logic                                done,
    output logic [2:0]                          status,
    output logic [dkpq_pkg::COURSE_W-1:0]       out_course,
    output logic [dkpq_pkg::NUMBER_W-1:0]       out_number,
    output logic [dkpq_pkg::MONTH_W-1:0]        out_month,
    output logic [dkpq_pkg::DAY_W-1:0]          out_day,
    output logic signed [dkpq_pkg::DAYS_W-1:0]  days_until_due
);
    import dkpq_pkg::*;

    localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W:0]   CAP_EXT = (CNT_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_HEAD,
        S_REM,
        S_QRY
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [PTR_W-1:0]           idx_reg, idx_next;
    logic [MONTH_W-1:0]         cur_month_reg;
    logic [DAY_W-1:0]           cur_day_reg;
    entry_t                     req_reg, req_next;

    logic                       done_reg, done_next;
    status_t                    status_reg, status_next;
    entry_t                     res_reg, res_next;
    logic signed [DAYS_W-1:0]   days_reg, days_next;

    logic                       wr_en;
    logic [PTR_W-1:0]           wr_addr;
    entry_t                     wr_data;
    logic                       rd_en;
    logic [PTR_W-1:0]           rd_addr;
    entry_t                     rd_data;
    alu_res_t                   alu;
    entry_t                     in_entry;
    logic                       in_bad;

    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        begin
            sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(pos);
            if (sum >= CAP_EXT)
            begin
                sum = sum - CAP_EXT;
            end
            return sum[PTR_W-1:0];
        end
    endfunction

    dkpq_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dkpq_alu u_alu (
        .entry      (rd_data),
        .new_month  (req_reg.month),
        .new_day    (req_reg.day),
        .key_course (req_reg.course),
        .cur_month  (cur_month_reg),
        .cur_day    (cur_day_reg),
        .res        (alu)
    );

    assign in_entry.course = course_id;
    assign in_entry.number = item_number;
    assign in_entry.month  = due_month;
    assign in_entry.day    = due_day;

    assign in_bad = (due_month == '0) || (due_month > MONTH_MAX) ||
                    (due_day == '0) || (due_day > DAY_MAX) ||
                    (course_id >= NO_COURSE);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        req_next    = req_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        res_next    = res_reg;
        days_next   = days_reg;
        wr_en       = 1'b0;
        wr_addr     = head_reg;
        wr_data     = req_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = in_entry;
                    res_next    = '0;
                    days_next   = '0;
                    status_next = ST_OK;
                    case (func_t'(func))
                        FN_INSERT:
                        begin
                            if (in_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_INVALID;
                            end
                            else if (count_reg == CAP_CNT)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = head_reg;
                                wr_data    = in_entry;
                                count_next = count_reg + CNT_W'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                idx_next   = PTR_W'(count_reg - CNT_W'(1));
                                rd_en      = 1'b1;
                                rd_addr    = phys(head_reg, count_reg - CNT_W'(1));
                                state_next = S_INS;
                            end
                        end
                        FN_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = S_REM;
                            end
                        end
                        FN_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                idx_next   = '0;
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = S_QRY;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, CNT_W'(idx_reg) + CNT_W'(1));
                if (alu.earlier)
                begin
                    // move the later entry up one place
                    wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_HEAD;
                    end
                    else
                    begin
                        idx_next = idx_reg - PTR_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = phys(head_reg, CNT_W'(idx_reg) - CNT_W'(1));
                    end
                end
                else
                begin
                    wr_data    = req_reg;
                    count_next = count_reg + CNT_W'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_INS_HEAD:
            begin
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                wr_data    = req_reg;
                count_next = count_reg + CNT_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_REM:
            begin
                res_next   = rd_data;
                head_next  = phys(head_reg, CNT_W'(1));
                count_next = count_reg - CNT_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_QRY:
            begin
                if (alu.match)
                begin
                    days_next  = alu.days;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg)
                begin
                    status_next = ST_NOTFOUND;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + PTR_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = phys(head_reg, CNT_W'(idx_reg) + CNT_W'(1));
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            done_reg      <= 1'b0;
            req_reg       <= '0;
            status_reg    <= ST_OK;
            res_reg       <= '0;
            days_reg      <= '0;
            cur_month_reg <= MONTH_W'(1);
            cur_day_reg   <= DAY_W'(1);
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            head_reg   <= head_next;
            idx_reg    <= idx_next;
            done_reg   <= done_next;
            req_reg    <= req_next;
            status_reg <= status_next;
            res_reg    <= res_next;
            days_reg   <= days_next;
            if (cfg_wr_en)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_MONTH: cur_month_reg <= cfg_data[MONTH_W-1:0];
                    CFG_DAY:   cur_day_reg   <= cfg_data;
                    default:   cur_day_reg   <= cur_day_reg;
                endcase
            end
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign out_course     = res_reg.course;
    assign out_number     = res_reg.number;
    assign out_month      = res_reg.month;
    assign out_day        = res_reg.day;
    assign days_until_due = days_reg;

endmodule

// ===== rtl/core/dkpq_checker.sv =====
// ----------------------------------------------------------------------------
// dkpq_checker
// port level checks of the date keyed priority queue, bound to the top level
// ----------------------------------------------------------------------------
module dkpq_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          func,
    input  logic                                done,
    input  logic [2:0]                          status,
    input  logic [dkpq_pkg::NUMBER_W-1:0]       out_number,
    input  logic signed [dkpq_pkg::DAYS_W-1:0]  days_until_due
);
    import dkpq_pkg::*;

    // result cycle always ends the command
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= 3'(ST_NOTFOUND)))
        else $error("status code out of range");

    // unknown operation is rejected at once
    a_unknown_op: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == 2'(FN_NONE)) |=>
            (done && status == 3'(ST_INVALID)))
        else $error("unknown operation not rejected");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != 3'(ST_OK)) |-> (out_number == '0 && days_until_due == '0))
        else $error("payload not cleared on failed transfer");

endmodule

bind date_keyed_priority_queue_top dkpq_checker u_dkpq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .done           (done),
    .status         (status),
    .out_number     (out_number),
    .days_until_due (days_until_due)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the date keyed priority queue: a directed table
// walks the invalid, empty and not found codes and field extremes, then
// several phases of random insert, remove and days queries under different
// dates check every result against a queue model kept in the bench
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dkpq_pkg::*;

    localparam int CAPACITY = 16;
    localparam int NUM_ROWS = 25;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int QUIET_PHASE = 3;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } mode_t;

    typedef struct packed {
        func_t               op;
        logic [COURSE_W-1:0] course;
        logic [NUMBER_W-1:0] number;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } command_t;

    typedef struct packed {
        status_t                  status;
        logic [COURSE_W-1:0]      course;
        logic [NUMBER_W-1:0]      number;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic signed [DAYS_W-1:0] days;
    } outcome_t;

    typedef struct packed {
        command_t cmd;
        logic     typed;
        outcome_t want;
    } row_t;

    localparam row_t SCRIPT [NUM_ROWS] = '{
        '{'{FN_REMOVE, 3'd0, 16'h0000, 4'd0, 5'd0}, 1'b1,
          '{ST_EMPTY, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_QUERY, 3'd0, 16'h0000, 4'd0, 5'd0}, 1'b1,
          '{ST_NOTFOUND, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_NONE, 3'd7, 16'hFFFF, 4'd15, 5'd31}, 1'b1,
          '{ST_INVALID, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_INSERT, 3'd0, 16'h0000, 4'd0, 5'd1}, 1'b1,
          '{ST_INVALID, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_INSERT, 3'd0, 16'h0001, 4'd13, 5'd1}, 1'b1,
          '{ST_INVALID, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_INSERT, 3'd0, 16'h0002, 4'd15, 5'd31}, 1'b1,
          '{ST_INVALID, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_INSERT, 3'd0, 16'h0003, 4'd1, 5'd0}, 1'b1,
          '{ST_INVALID, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_INSERT, 3'd6, 16'h0004, 4'd1, 5'd1}, 1'b1,
          '{ST_INVALID, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_INSERT, 3'd7, 16'hFFFF, 4'd12, 5'd31}, 1'b1,
          '{ST_INVALID, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_INSERT, 3'd0, 16'h0000, 4'd1, 5'd1}, 1'b1,
          '{ST_OK, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_REMOVE, 3'd0, 16'h0000, 4'd0, 5'd0}, 1'b1,
          '{ST_OK, 3'd0, 16'h0000, 4'd1, 5'd1, 10'sd0}},
        '{'{FN_INSERT, 3'd5, 16'hFFFF, 4'd12, 5'd31}, 1'b1,
          '{ST_OK, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_QUERY, 3'd5, 16'h0000, 4'd0, 5'd0}, 1'b1,
          '{ST_OK, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd360}},
        '{'{FN_QUERY, 3'd6, 16'h0000, 4'd0, 5'd0}, 1'b1,
          '{ST_NOTFOUND, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_QUERY, 3'd7, 16'h0000, 4'd0, 5'd0}, 1'b1,
          '{ST_NOTFOUND, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}},
        '{'{FN_INSERT, 3'd3, 16'h1234, 4'd12, 5'd31}, 1'b0, '0},
        '{'{FN_INSERT, 3'd1, 16'h00FF, 4'd1, 5'd1}, 1'b0, '0},
        '{'{FN_INSERT, 3'd2, 16'hA5A5, 4'd6, 5'd15}, 1'b0, '0},
        '{'{FN_INSERT, 3'd2, 16'h5A5A, 4'd6, 5'd15}, 1'b0, '0},
        '{'{FN_QUERY, 3'd2, 16'h0000, 4'd0, 5'd0}, 1'b0, '0},
        '{'{FN_QUERY, 3'd3, 16'h0000, 4'd0, 5'd0}, 1'b0, '0},
        '{'{FN_REMOVE, 3'd0, 16'h0000, 4'd0, 5'd0}, 1'b0, '0},
        '{'{FN_REMOVE, 3'd0, 16'h0000, 4'd0, 5'd0}, 1'b0, '0},
        '{'{FN_REMOVE, 3'd0, 16'h0000, 4'd0, 5'd0}, 1'b0, '0},
        '{'{FN_QUERY, 3'd4, 16'h0000, 4'd0, 5'd0}, 1'b1,
          '{ST_NOTFOUND, 3'd0, 16'h0000, 4'd0, 5'd0, 10'sd0}}
    };

    localparam mode_t PHASE_MODE [PHASES] = '{
        MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_FILL, MODE_MIXED, MODE_DRAIN
    };
    localparam logic [DAY_W-1:0] PHASE_MONTH [4] = '{5'd12, 5'd15, 5'd0, 5'd1};
    localparam logic [DAY_W-1:0] PHASE_DAY [4] = '{5'd31, 5'd31, 5'd0, 5'd1};

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic                       cfg_index;
    logic [DAY_W-1:0]           cfg_data;
    logic                       start;
    logic                       busy;
    logic [1:0]                 func;
    logic [COURSE_W-1:0]        course_id;
    logic [NUMBER_W-1:0]        item_number;
    logic [MONTH_W-1:0]         due_month;
    logic [DAY_W-1:0]           due_day;
    logic                       done;
    logic [2:0]                 status;
    logic [COURSE_W-1:0]        out_course;
    logic [NUMBER_W-1:0]        out_number;
    logic [MONTH_W-1:0]         out_month;
    logic [DAY_W-1:0]           out_day;
    logic signed [DAYS_W-1:0]   days_until_due;

    // queue model
    entry_t           shelf [CAPACITY+1];
    int               held = 0;
    logic [MONTH_W-1:0] today_month = MONTH_W'(1);
    logic [DAY_W-1:0]   today_day = DAY_W'(1);

    outcome_t         pending_outcomes [$];
    int               failures = 0;

    date_keyed_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .func(func),
        .course_id(course_id),
        .item_number(item_number),
        .due_month(due_month),
        .due_day(due_day),
        .done(done),
        .status(status),
        .out_course(out_course),
        .out_number(out_number),
        .out_month(out_month),
        .out_day(out_day),
        .days_until_due(days_until_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic outcome_t apply_command(command_t c);
        outcome_t r;
        int       slot;
        int       i;
        int       dm;
        int       dd;
        logic     found;
        r = '0;
        r.status = ST_OK;
        case (c.op)
            FN_INSERT:
            begin
                if (c.month == 0 || c.month > MONTH_MAX || c.day == 0 || c.course >= NO_COURSE)
                    r.status = ST_INVALID;
                else if (held >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    slot = held;
                    for (i = 0; i < held; i++)
                        if (slot == held && (c.month < shelf[i].month ||
                            (c.month == shelf[i].month && c.day < shelf[i].day)))
                            slot = i;
                    for (i = held; i > slot; i--)
                        shelf[i] = shelf[i-1];
                    shelf[slot] = '{c.course, c.number, c.month, c.day};
                    held++;
                end
            end
            FN_REMOVE:
            begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.course = shelf[0].course;
                    r.number = shelf[0].number;
                    r.month = shelf[0].month;
                    r.day = shelf[0].day;
                    for (i = 1; i < held; i++)
                        shelf[i-1] = shelf[i];
                    held--;
                end
            end
            FN_QUERY:
            begin
                found = 1'b0;
                for (i = 0; i < held; i++)
                    if (!found && shelf[i].course == c.course)
                    begin
                        found = 1'b1;
                        dm = int'(shelf[i].month) - int'(today_month);
                        dd = int'(shelf[i].day) - int'(today_day);
                        r.days = DAYS_W'(dm * int'(DAYS_PER_MONTH) + dd);
                    end
                if (!found)
                    r.status = ST_NOTFOUND;
            end
            default: r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    function automatic command_t draw_command(mode_t mode);
        command_t c;
        int       roll;
        int       insert_pct;
        int       remove_pct;
        insert_pct = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 20 : 45;
        remove_pct = (mode == MODE_FILL) ? 20 : (mode == MODE_DRAIN) ? 60 : 35;
        c.number = NUMBER_W'($urandom);
        c.course = COURSE_W'($urandom_range(0, 5));
        // half the dates come from a narrow pool so ties and near ties are common
        if ($urandom_range(0, 1) == 0)
        begin
            c.month = MONTH_W'($urandom_range(1, 12));
            c.day = DAY_W'($urandom_range(1, 31));
        end
        else
        begin
            c.month = MONTH_W'($urandom_range(6, 7));
            c.day = DAY_W'($urandom_range(1, 3));
        end
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            c.op = FN_INSERT;
        else if (roll < insert_pct + remove_pct)
            c.op = FN_REMOVE;
        else
            c.op = FN_QUERY;
        if ($urandom_range(0, 99) < 8)
        begin
            case ($urandom_range(0, 3))
                0: c.op = FN_NONE;
                1: c.month = ($urandom_range(0, 1) == 0) ? MONTH_W'(0)
                                                         : MONTH_W'($urandom_range(13, 15));
                2: c.day = DAY_W'(0);
                default: c.course = COURSE_W'($urandom_range(6, 7));
            endcase
        end
        return c;
    endfunction

    // present one command and hold it until the transfer
    task automatic issue(command_t c, logic typed, outcome_t want, logic may_idle);
        outcome_t predicted;
        if (may_idle && $urandom_range(0, 99) < 17)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start <= 1'b1;
        func <= c.op;
        course_id <= c.course;
        item_number <= c.number;
        due_month <= c.month;
        due_day <= c.day;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_command(c);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic set_date(logic [DAY_W-1:0] month_value, logic [DAY_W-1:0] day_value);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MONTH;
        cfg_data <= month_value;
        @(posedge clk);
        today_month = month_value[MONTH_W-1:0];
        cfg_index <= CFG_DAY;
        cfg_data <= day_value;
        @(posedge clk);
        today_day = day_value;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: status %0d course %0d number %h date %0d/%0d days %0d",
                             status, out_course, out_number, out_month, out_day, days_until_due);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status || out_course !== want.course ||
                    out_number !== want.number || out_month !== want.month ||
                    out_day !== want.day || days_until_due !== want.days)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                    begin
                        $display("mismatch at %0t: expected status %0d course %0d number %h date %0d/%0d days %0d",
                                 $realtime, want.status, want.course, want.number, want.month,
                                 want.day, want.days);
                        $display("                 actual status %0d course %0d number %h date %0d/%0d days %0d",
                                 status, out_course, out_number, out_month, out_day,
                                 days_until_due);
                    end
                end
            end
        end
    end

    initial
    begin
        logic [DAY_W-1:0] month_value;
        logic [DAY_W-1:0] day_value;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MONTH;
        cfg_data = '0;
        start = 1'b0;
        func = FN_INSERT;
        course_id = '0;
        item_number = '0;
        due_month = '0;
        due_day = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset date
        for (int r = 0; r < NUM_ROWS; r++)
            issue(SCRIPT[r].cmd, SCRIPT[r].typed, SCRIPT[r].want, 1'b1);

        // random phases, each under its own date
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 4)
            begin
                month_value = PHASE_MONTH[p];
                day_value = PHASE_DAY[p];
            end
            else
            begin
                month_value = DAY_W'($urandom_range(1, 12));
                day_value = DAY_W'($urandom_range(1, 31));
            end
            set_date(month_value, day_value);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                issue(draw_command(PHASE_MODE[p]), 1'b0, '0, p != QUIET_PHASE);
        end

        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
